// File: rtl/mck_pkg.sv
// Shared types, constants and the Morse pattern table for the character keyer.
package mck_pkg;

  localparam int DurW    = 14;
  localparam int CharW   = 8;
  localparam int CfgIdxW = 2;
  localparam int ElemW   = 5;  // longest pattern has five elements
  localparam int LenW    = 3;
  localparam int SlotW   = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDot       = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDash      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCharPause = 2'd2;
  localparam logic [CfgIdxW-1:0] RegWordSpace = 2'd3;

  localparam logic [DurW-1:0] DotRst       = 14'd60;
  localparam logic [DurW-1:0] DashRst      = 14'd180;
  localparam logic [DurW-1:0] CharPauseRst = 14'd180;
  localparam logic [DurW-1:0] WordSpaceRst = 14'd420;

  localparam logic [CharW-1:0] ChrUpA  = 8'h41;
  localparam logic [CharW-1:0] ChrUpZ  = 8'h5A;
  localparam logic [CharW-1:0] ChrLoA  = 8'h61;
  localparam logic [CharW-1:0] ChrLoZ  = 8'h7A;
  localparam logic [CharW-1:0] ChrZero = 8'h30;
  localparam logic [CharW-1:0] ChrNine = 8'h39;
  localparam logic [SlotW-1:0] DigitBase = 6'd26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_TONE,
    ST_GAP,
    ST_SPACE,
    ST_PAUSE
  } state_t;

  // element pattern: a 1 is a dash, first element in bit ElemW-1
  typedef struct packed {
    logic             valid;
    logic [LenW-1:0]  len;
    logic [ElemW-1:0] bits;
  } pat_t;

  // raw table: first element sits in the highest of len bits
  function automatic pat_t mck_table(input logic [SlotW-1:0] slot);
    pat_t p;
    p.valid = 1'b1;
    case (slot)
      6'd0:  begin p.len = 3'd2; p.bits = 5'h01; end
      6'd1:  begin p.len = 3'd4; p.bits = 5'h08; end
      6'd2:  begin p.len = 3'd4; p.bits = 5'h0A; end
      6'd3:  begin p.len = 3'd3; p.bits = 5'h04; end
      6'd4:  begin p.len = 3'd1; p.bits = 5'h00; end
      6'd5:  begin p.len = 3'd4; p.bits = 5'h02; end
      6'd6:  begin p.len = 3'd3; p.bits = 5'h06; end
      6'd7:  begin p.len = 3'd4; p.bits = 5'h00; end
      6'd8:  begin p.len = 3'd2; p.bits = 5'h00; end
      6'd9:  begin p.len = 3'd4; p.bits = 5'h07; end
      6'd10: begin p.len = 3'd3; p.bits = 5'h05; end
      6'd11: begin p.len = 3'd4; p.bits = 5'h04; end
      6'd12: begin p.len = 3'd2; p.bits = 5'h03; end
      6'd13: begin p.len = 3'd2; p.bits = 5'h02; end
      6'd14: begin p.len = 3'd3; p.bits = 5'h07; end
      6'd15: begin p.len = 3'd4; p.bits = 5'h06; end
      6'd16: begin p.len = 3'd4; p.bits = 5'h0D; end
      6'd17: begin p.len = 3'd3; p.bits = 5'h02; end
      6'd18: begin p.len = 3'd3; p.bits = 5'h00; end
      6'd19: begin p.len = 3'd1; p.bits = 5'h01; end
      6'd20: begin p.len = 3'd3; p.bits = 5'h01; end
      6'd21: begin p.len = 3'd4; p.bits = 5'h01; end
      6'd22: begin p.len = 3'd3; p.bits = 5'h03; end
      6'd23: begin p.len = 3'd4; p.bits = 5'h09; end
      6'd24: begin p.len = 3'd4; p.bits = 5'h0B; end
      6'd25: begin p.len = 3'd4; p.bits = 5'h0C; end
      6'd26: begin p.len = 3'd5; p.bits = 5'h1F; end
      6'd27: begin p.len = 3'd5; p.bits = 5'h0F; end
      6'd28: begin p.len = 3'd5; p.bits = 5'h07; end
      6'd29: begin p.len = 3'd5; p.bits = 5'h03; end
      6'd30: begin p.len = 3'd5; p.bits = 5'h01; end
      6'd31: begin p.len = 3'd5; p.bits = 5'h00; end
      6'd32: begin p.len = 3'd5; p.bits = 5'h10; end
      6'd33: begin p.len = 3'd5; p.bits = 5'h18; end
      6'd34: begin p.len = 3'd5; p.bits = 5'h1C; end
      6'd35: begin p.len = 3'd5; p.bits = 5'h1E; end
      default: begin p.valid = 1'b0; p.len = 3'd0; p.bits = 5'h00; end
    endcase
    return p;
  endfunction

endpackage

// File: rtl/mck_lookup.sv
// Character classifier and Morse table lookup, pattern left-aligned for shifting.
module mck_lookup
  import mck_pkg::*;
(
  input  logic [CharW-1:0] char_code,
  output pat_t             pat
);

  logic [SlotW-1:0] slot;
  logic             known;
  pat_t             raw;

  always_comb begin
    known = 1'b1;
    slot  = '0;
    if (char_code inside {[ChrUpA:ChrUpZ]}) begin
      slot = SlotW'(char_code - ChrUpA);
    end else if (char_code inside {[ChrLoA:ChrLoZ]}) begin
      slot = SlotW'(char_code - ChrLoA);
    end else if (char_code inside {[ChrZero:ChrNine]}) begin
      slot = DigitBase + SlotW'(char_code - ChrZero);
    end else begin
      known = 1'b0;
    end
  end

  assign raw = mck_table(slot);

  // move the first element up to the top bit
  always_comb begin
    pat.valid = known & raw.valid;
    pat.len   = raw.len;
    pat.bits  = ElemW'(raw.bits << (LenW'(ElemW) - raw.len));
  end

endmodule

// File: rtl/morse_character_keyer_top.sv
// Top level of the Morse character keyer: config registers, sequencer, result register.
//
//   channel  direction  handshake                      payload
//   -------  ---------  -----------------------------  ------------------------------------
//   in_      in         start && !busy                 in_char_code[7:0]
//   out_     out        out_valid, one cycle, no stall out_tone_on, out_seg_ms, out_last
//   cfg_     in         cfg_valid && cfg_ready         cfg_index[1:0], cfg_data[13:0]
//
// A letter or digit passes through the lookup state, a tone and a gap state
// per element and the pause state; any other byte through the lookup, space
// and pause states. The element shifter emits one segment per cycle. The first
// segment leaves the result register after the lookup and the first tone or
// space state. rst_n (synchronous) returns the registers to 60/180/180/420 ms
// and idles the sequencer. Results cannot be stalled; cfg_ready is always high.
module morse_character_keyer_top
  import mck_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CharW-1:0]   in_char_code,
  output logic               out_valid,
  output logic               out_tone_on,
  output logic [DurW-1:0]    out_seg_ms,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DurW-1:0]    cfg_data
);

  // configuration registers
  logic [DurW-1:0] dot_r, dash_r, char_pause_r, word_space_r;

  state_t state_r, state_nxt;

  logic [CharW-1:0] char_r;
  logic [ElemW-1:0] bits_r, bits_nxt;
  logic [LenW-1:0]  cnt_r, cnt_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            tone_r, tone_nxt;
  logic [DurW-1:0] dur_r, dur_nxt;
  logic            last_r, last_nxt;

  pat_t pat;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);

  // config writes; the four indexes cover every value, so the default arm is never taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r        <= DotRst;
      dash_r       <= DashRst;
      char_pause_r <= CharPauseRst;
      word_space_r <= WordSpaceRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegDot:       dot_r        <= cfg_data;
        RegDash:      dash_r       <= cfg_data;
        RegCharPause: char_pause_r <= cfg_data;
        RegWordSpace: word_space_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the accepted byte for the lookup cycle
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      char_r <= in_char_code;
    end
  end

  mck_lookup u_lookup (
    .char_code (char_r),
    .pat       (pat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = pat.valid ? ST_TONE : ST_SPACE;
      ST_TONE:   state_nxt = ST_GAP;
      ST_GAP:    state_nxt = (cnt_r == LenW'(1)) ? ST_PAUSE : ST_TONE;
      ST_SPACE:  state_nxt = ST_PAUSE;
      ST_PAUSE:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and element shifter
  always_comb begin
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    tone_nxt      = 1'b0;
    dur_nxt       = dot_r;
    last_nxt      = 1'b0;
    case (state_r)
      ST_LOOKUP: begin
        bits_nxt = pat.bits;
        cnt_nxt  = pat.len;
      end
      ST_TONE: begin
        out_valid_nxt = 1'b1;
        tone_nxt      = 1'b1;
        dur_nxt       = bits_r[ElemW-1] ? dash_r : dot_r;
      end
      ST_GAP: begin
        // intra-character gap, then advance to the next element
        out_valid_nxt = 1'b1;
        dur_nxt       = dot_r;
        bits_nxt      = {bits_r[ElemW-2:0], 1'b0};
        cnt_nxt       = cnt_r - LenW'(1);
      end
      ST_SPACE: begin
        out_valid_nxt = 1'b1;
        dur_nxt       = word_space_r;
      end
      ST_PAUSE: begin
        out_valid_nxt = 1'b1;
        dur_nxt       = char_pause_r;
        last_nxt      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    cnt_r  <= cnt_nxt;
    tone_r <= tone_nxt;
    dur_r  <= dur_nxt;
    last_r <= last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_tone_on = tone_r;
  assign out_seg_ms  = dur_r;
  assign out_last    = last_r;

endmodule

// File: rtl/mck_checker.sv
// Port-level checks for the Morse character keyer, bound to the top level.
module mck_checker
  import mck_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input logic            out_tone_on,
  input logic            out_last
);

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // lookup cycle: nothing leaves right after an accept
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("result right after accept");

  // every tone is followed by a silent gap that is not the closing pause
  a_tone_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tone_on |=> out_valid && !out_tone_on && !out_last)
    else $error("tone not followed by gap");

  // the closing pause is silent and ends the character
  a_last_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_tone_on) else $error("closing pause has tone");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result after closing pause");

endmodule

bind morse_character_keyer_top mck_checker u_mck_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_tone_on (out_tone_on),
  .out_last    (out_last)
);

// File: test/tb.sv
// Self-checking testbench for the Morse character keyer: keys characters and checks every segment.
module tb
  import mck_pkg::*;
();

  localparam int StallLimit    = 1000;  // cycles with no handshake and no segment
  localparam int SettleCycles  = 4;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 40;
  localparam int MaxReports    = 50;
  localparam int NumDirected   = 22;

  // One keying segment as it leaves the result ports.
  typedef struct packed {
    logic            tone_on;
    logic [DurW-1:0] seg_ms;
    logic            last;
  } segment_t;

  // Keeps the timing registers, expands each accepted character into its
  // segments and checks the segments in order as they come out.
  class keying_scoreboard;
    segment_t        expected_segments[$];
    string           morse_of[36];
    logic [DurW-1:0] dot_len;
    logic [DurW-1:0] dash_len;
    logic [DurW-1:0] pause_len;
    logic [DurW-1:0] space_len;
    int              errors;
    int              seen;

    function new();
      // letters A..Z, then digits 0..9
      morse_of = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                   ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                   "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
                   "-----", ".----", "..---", "...--", "....-", ".....", "-....",
                   "--...", "---..", "----."};
      dot_len   = DotRst;
      dash_len  = DashRst;
      pause_len = CharPauseRst;
      space_len = WordSpaceRst;
      errors    = 0;
      seen      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] data);
      case (idx)
        RegDot:       dot_len   = data;
        RegDash:      dash_len  = data;
        RegCharPause: pause_len = data;
        RegWordSpace: space_len = data;
        default: ;
      endcase
    endfunction

    function void add_segment(logic tone, logic [DurW-1:0] dur, logic last);
      segment_t s;
      s.tone_on = tone;
      s.seg_ms  = dur;
      s.last    = last;
      expected_segments.push_back(s);
    endfunction

    function void note_char(logic [CharW-1:0] code);
      int    slot;
      string pat;
      slot = -1;
      if (code >= ChrUpA && code <= ChrUpZ) begin
        slot = int'(code - ChrUpA);
      end else if (code >= ChrLoA && code <= ChrLoZ) begin
        slot = int'(code - ChrLoA);
      end else if (code >= ChrZero && code <= ChrNine) begin
        slot = int'(DigitBase) + int'(code - ChrZero);
      end
      if (slot >= 0) begin
        pat = morse_of[slot];
        for (int i = 0; i < pat.len(); i++) begin
          add_segment(1'b1, (pat[i] == "-") ? dash_len : dot_len, 1'b0);
          add_segment(1'b0, dot_len, 1'b0);
        end
      end else begin
        add_segment(1'b0, space_len, 1'b0);
      end
      add_segment(1'b0, pause_len, 1'b1);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxReports) begin
        $display("tb: mismatch: %s", msg);
      end
    endtask

    task check_segment(logic tone, logic [DurW-1:0] dur, logic last);
      segment_t want;
      seen++;
      if (expected_segments.size() == 0) begin
        report($sformatf("segment %0d: none expected", seen));
        return;
      end
      want = expected_segments.pop_front();
      if (tone !== want.tone_on) begin
        report($sformatf("segment %0d: tone_on got %b want %b", seen, tone, want.tone_on));
      end
      if (dur !== want.seg_ms) begin
        report($sformatf("segment %0d: seg_ms got %0d want %0d",
                         seen, dur, want.seg_ms));
      end
      if (last !== want.last) begin
        report($sformatf("segment %0d: last got %b want %b", seen, last, want.last));
      end
    endtask

    function int pending();
      return expected_segments.size();
    endfunction
  endclass

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               start        = 1'b0;
  logic               busy;
  logic [CharW-1:0]   in_char_code = '0;
  logic               out_valid;
  logic               out_tone_on;
  logic [DurW-1:0]    out_seg_ms;
  logic               out_last;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index    = RegDot;
  logic [DurW-1:0]    cfg_data     = '0;

  keying_scoreboard segments;
  int               stall_cycles = 0;

  always #10 clk = ~clk;

  morse_character_keyer_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_tone_on  (out_tone_on),
    .out_seg_ms   (out_seg_ms),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Sample every handshake at the rising edge, from the values that held
  // during the cycle just ended. Check the segment before noting a new
  // item: a segment in the accept cycle cannot belong to that item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        segments.check_segment(out_tone_on, out_seg_ms, out_last);
      end
      if (start && !busy) begin
        segments.note_char(in_char_code);
      end
      if (cfg_valid && cfg_ready) begin
        segments.set_reg(cfg_index, cfg_data);
      end
    end
    // count cycles in which nothing moves; any handshake or segment clears it
    if (rst_n && (out_valid || (start && !busy) || (cfg_valid && cfg_ready))) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
  end

  // Watchdog: look at the count away from the rising edge so it never races
  // the monitor above.
  initial begin : watchdog
    do @(negedge clk); while (stall_cycles < StallLimit);
    $display("tb: failure");
    $finish;
  end

  // Hold until every expected segment has come out. Poll on the falling
  // edge, then return on a rising edge so drives stay edge aligned.
  task automatic wait_drained();
    do @(negedge clk); while (segments.pending() != 0);
    @(posedge clk);
  endtask

  // Drop start, drain, and let the sequencer settle before touching config.
  task automatic settle_idle();
    start <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Present one register write and hold it until the channel takes it.
  // Valid stays high so back-to-back writes need no extra cycle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_timing(input logic [DurW-1:0] dot, input logic [DurW-1:0] dash,
                                input logic [DurW-1:0] pause, input logic [DurW-1:0] space);
    write_reg(RegDot, dot);
    write_reg(RegDash, dash);
    write_reg(RegCharPause, pause);
    write_reg(RegWordSpace, space);
    cfg_valid <= 1'b0;
  endtask

  // Offer one character and hold start until the block takes it. Start is
  // left high on return so the next item can follow with no gap; a gap or a
  // drain lowers it here, at a later edge than the one that raised it.
  task automatic key_char(input logic [CharW-1:0] code, input int idle_pct,
                          input bit drain_first);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(16, 1)) : 0;
    if (gap > 0 || drain_first) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain_first) begin
        wait_drained();
      end
    end
    start        <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly letters and digits, which walk the element shifter; the rest is
  // any byte at all, which covers every bit and the word-space path.
  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = int'($urandom_range(99));
    if (r < 35) begin
      return ChrUpA + CharW'($urandom_range(25));
    end else if (r < 60) begin
      return ChrLoA + CharW'($urandom_range(25));
    end else if (r < 80) begin
      return ChrZero + CharW'($urandom_range(9));
    end
    return CharW'($urandom_range(255));
  endfunction

  initial begin
    logic [CharW-1:0] directed_chars [NumDirected];
    int               idle_pct;

    segments = new();

    // Table ends, both cases, the nine that was once sent as a space, the
    // one-element letters, and the bytes just outside each character range.
    directed_chars = '{ChrUpA, ChrUpZ, ChrLoA, ChrLoZ, ChrZero, ChrNine,
                       8'h45, 8'h54, 8'h51, 8'h35, 8'h6D,
                       8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20,
                       ChrUpA - 8'd1, ChrUpZ + 8'd1, ChrLoA - 8'd1, ChrLoZ + 8'd1,
                       ChrZero - 8'd1, ChrNine + 8'd1};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset timing, back to back
    foreach (directed_chars[i]) begin
      key_char(directed_chars[i], 0, 1'b0);
    end

    // Random phases: the timing changes only while the block is idle.
    // Sender idling cycles through none, heavy and light.
    for (int p = 0; p < NumPhases; p++) begin
      settle_idle();
      case (p)
        0:       program_timing(14'd1, 14'd10000, 14'd1, 14'd10000);
        1:       program_timing(14'd10000, 14'd1, 14'd10000, 14'd1);
        2:       program_timing(14'd0, 14'h3FFF, 14'h3FFF, 14'd0);  // used as written
        default: program_timing(DurW'($urandom_range(10000, 1)), DurW'($urandom_range(10000, 1)),
                                DurW'($urandom_range(10000, 1)), DurW'($urandom_range(10000, 1)));
      endcase
      idle_pct = (p % 3 == 1) ? 72 : ((p % 3 == 2) ? 6 : 0);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        // now and then hold the sender off until the keyer has drained
        key_char(pick_char(), idle_pct,
                 (idle_pct > 0) && (k == ItemsPerPhase / 2 || $urandom_range(19) == 0));
      end
    end

    settle_idle();
    if (segments.errors == 0 && segments.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
